[rtl/core/gds_pkg.sv]
package gds_pkg;

    localparam int GRID_W_BITS    = 11;
    localparam int ROW_BITS       = 16;
    localparam int INV_BITS       = 16;
    localparam int DIV_BITS       = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int NUM_POINTS     = 4;
    localparam int PT_BITS        = 2;
    localparam int QUEUE_DEPTH    = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_INV       = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_INV       = CFG_INDEX_BITS'(3);

    localparam logic [GRID_W_BITS-1:0] GRID_W_RESET = GRID_W_BITS'(2);
    localparam logic [ROW_BITS-1:0]    GRID_H_RESET = ROW_BITS'(2);
    localparam logic [INV_BITS-1:0]    INV_RESET    = INV_BITS'(256);

    // points a sample can complete, in emission order
    localparam logic [PT_BITS-1:0] PT_INNER    = PT_BITS'(0); // (i-1, j-1)
    localparam logic [PT_BITS-1:0] PT_ROW_END  = PT_BITS'(1); // (W-1, j-1)
    localparam logic [PT_BITS-1:0] PT_LAST_ROW = PT_BITS'(2); // (i-1, H-1)
    localparam logic [PT_BITS-1:0] PT_CORNER   = PT_BITS'(3); // (W-1, H-1)

    typedef struct packed {
        logic [GRID_W_BITS-1:0] grid_width;
        logic [ROW_BITS-1:0]    grid_height;
        logic                   restart;
    } dims_t;

    // width of one queue entry: masks, flags, coordinates, x and y differences
    function automatic int entry_bits(input int cw, input int dw);
        return 3 * NUM_POINTS + cw + ROW_BITS + 2 * NUM_POINTS * dw;
    endfunction

endpackage

[rtl/core/gds_ram.sv]
module gds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gds_front.sv]
module gds_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int DW         = SAMPLE_BITS + 1,
    localparam int ENTRY_W    = gds_pkg::entry_bits(CW, DW)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gds_pkg::dims_t         dims,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] vx_sample,
    input  logic [SAMPLE_BITS-1:0] vy_sample,
    output logic                   q_push,
    output logic [ENTRY_W-1:0]     q_data,
    input  logic                   q_full
);

    import gds_pkg::*;

    localparam int SB = SAMPLE_BITS;

    typedef struct packed {
        logic [NUM_POINTS-1:0]         mask;
        logic [NUM_POINTS-1:0]         x_one;
        logic [NUM_POINTS-1:0]         y_one;
        logic [CW-1:0]                 col;
        logic [ROW_BITS-1:0]           row;
        logic [NUM_POINTS-1:0][DW-1:0] dx;
        logic [NUM_POINTS-1:0][DW-1:0] dy;
    } entry_t;

    function automatic logic [DW-1:0] diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
        return {a[SB-1], a} - {b[SB-1], b};
    endfunction

    logic [CW-1:0]       last_col;
    logic [ROW_BITS-1:0] last_row;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                in_acc;

    logic                s1_valid_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic                s1_last_col_reg;
    logic                s1_last_row_reg;
    logic [SB-1:0]       s1_vx_reg, s1_vy_reg;
    logic                s1_adv;

    // column window: _1 is column i-1, _2 is column i-2
    // x0 = row j, x1 = row j-1, y0/y1/y2 = rows j, j-1, j-2
    logic [SB-1:0] x0_1_reg, x0_2_reg, x1_1_reg, x1_2_reg;
    logic [SB-1:0] y0_1_reg, y1_1_reg, y2_1_reg;

    logic [3*SB-1:0] rd_data;
    logic [SB-1:0]   rd_vx1, rd_vy1, rd_vy2;
    logic            a_x_one, a_y_one, row_nz, col_nz;
    entry_t          entry;

    // effective grid extent
    always_comb
    begin
        if (dims.grid_width < GRID_W_BITS'(2))
        begin
            last_col = CW'(1);
        end
        else if (32'(dims.grid_width) > MAX_WIDTH)
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(dims.grid_width - GRID_W_BITS'(1));
        end
        if (dims.grid_height < ROW_BITS'(2))
        begin
            last_row = ROW_BITS'(1);
        end
        else
        begin
            last_row = dims.grid_height - ROW_BITS'(1);
        end
    end

    assign in_acc   = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_reg == last_col)
        begin
            col_next = '0;
            row_next = (row_reg == last_row) ? '0 : row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (dims.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= (col_reg == last_col);
            s1_last_row_reg <= (row_reg == last_row);
            s1_vx_reg       <= vx_sample;
            s1_vy_reg       <= vy_sample;
        end
        if (s1_adv)
        begin
            x0_1_reg <= s1_vx_reg;
            x0_2_reg <= x0_1_reg;
            x1_1_reg <= rd_vx1;
            x1_2_reg <= x1_1_reg;
            y0_1_reg <= s1_vy_reg;
            y1_1_reg <= rd_vy1;
            y2_1_reg <= rd_vy2;
        end
    end

    // one entry per column: {vx row j-1, vy row j-1, vy row j-2}
    gds_ram #(
        .WIDTH(3 * SB),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (s1_adv),
        .waddr(s1_col_reg),
        .wdata({s1_vx_reg, s1_vy_reg, rd_vy1}),
        .re   (in_acc),
        .raddr(col_reg),
        .rdata(rd_data)
    );

    assign rd_vx1 = rd_data[3*SB-1:2*SB];
    assign rd_vy1 = rd_data[2*SB-1:SB];
    assign rd_vy2 = rd_data[SB-1:0];

    assign a_x_one = (s1_col_reg == CW'(1));
    assign a_y_one = (s1_row_reg == ROW_BITS'(1));
    assign row_nz  = (s1_row_reg != '0);
    assign col_nz  = (s1_col_reg != '0);

    always_comb
    begin
        entry.mask[PT_INNER]    = row_nz && col_nz;
        entry.mask[PT_ROW_END]  = row_nz && s1_last_col_reg;
        entry.mask[PT_LAST_ROW] = row_nz && s1_last_row_reg && col_nz;
        entry.mask[PT_CORNER]   = row_nz && s1_last_row_reg && s1_last_col_reg;

        entry.x_one[PT_INNER]    = a_x_one;
        entry.x_one[PT_ROW_END]  = 1'b1;
        entry.x_one[PT_LAST_ROW] = a_x_one;
        entry.x_one[PT_CORNER]   = 1'b1;

        entry.y_one[PT_INNER]    = a_y_one;
        entry.y_one[PT_ROW_END]  = a_y_one;
        entry.y_one[PT_LAST_ROW] = 1'b1;
        entry.y_one[PT_CORNER]   = 1'b1;

        entry.col = s1_col_reg;
        entry.row = s1_row_reg;

        // column 0 takes a forward difference, the last column a backward one
        entry.dx[PT_INNER]    = a_x_one ? diff(rd_vx1, x1_1_reg) : diff(rd_vx1, x1_2_reg);
        entry.dx[PT_ROW_END]  = diff(rd_vx1, x1_1_reg);
        entry.dx[PT_LAST_ROW] = a_x_one ? diff(s1_vx_reg, x0_1_reg)
                                        : diff(s1_vx_reg, x0_2_reg);
        entry.dx[PT_CORNER]   = diff(s1_vx_reg, x0_1_reg);

        // row 0 takes a forward difference, the last row a backward one
        entry.dy[PT_INNER]    = a_y_one ? diff(y0_1_reg, y1_1_reg) : diff(y0_1_reg, y2_1_reg);
        entry.dy[PT_ROW_END]  = a_y_one ? diff(s1_vy_reg, rd_vy1) : diff(s1_vy_reg, rd_vy2);
        entry.dy[PT_LAST_ROW] = diff(y0_1_reg, y1_1_reg);
        entry.dy[PT_CORNER]   = diff(s1_vy_reg, rd_vy1);
    end

    // samples that complete no point still pass through to update the line ram
    assign s1_adv = s1_valid_reg && ((entry.mask == '0) || !q_full);
    assign q_push = s1_valid_reg && (entry.mask != '0) && !q_full;
    assign q_data = entry;

endmodule

[rtl/core/gds_queue.sv]
module gds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] rdata,
    input  logic             pop
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/gds_back.sv]
module gds_back #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int DW         = SAMPLE_BITS + 1,
    localparam int ENTRY_W    = gds_pkg::entry_bits(CW, DW)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [gds_pkg::INV_BITS-1:0]    x_inv,
    input  logic [gds_pkg::INV_BITS-1:0]    y_inv,
    input  logic                            q_valid,
    input  logic [ENTRY_W-1:0]              q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [CW-1:0]                   point_x,
    output logic [gds_pkg::ROW_BITS-1:0]    point_y,
    output logic [gds_pkg::DIV_BITS-1:0]    divergence,
    output logic                            last_of_run,
    output logic                            end_of_frame
);

    import gds_pkg::*;

    localparam int PW    = DW + INV_BITS + 1;
    localparam int SUM_W = PW + 2;
    localparam int SHIFT = FRAC_BITS + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DIV_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [NUM_POINTS-1:0]         mask;
        logic [NUM_POINTS-1:0]         x_one;
        logic [NUM_POINTS-1:0]         y_one;
        logic [CW-1:0]                 col;
        logic [ROW_BITS-1:0]           row;
        logic [NUM_POINTS-1:0][DW-1:0] dx;
        logic [NUM_POINTS-1:0][DW-1:0] dy;
    } entry_t;

    entry_t                head;
    logic [NUM_POINTS-1:0] issued_reg, issued_next, avail, pick, rest;
    logic [PT_BITS-1:0]    sel;
    logic                  en, issue;
    logic signed [PW-1:0]  prod_x, prod_y;

    logic                 m_valid_reg;
    logic signed [PW-1:0] m_prod_x_reg, m_prod_y_reg;
    logic                 m_x_one_reg, m_y_one_reg;
    logic [CW-1:0]        m_px_reg;
    logic [ROW_BITS-1:0]  m_py_reg;
    logic                 m_last_reg, m_eof_reg;

    logic signed [SUM_W-1:0] tx_ext, ty_ext, sum, shifted;
    logic [DIV_BITS-1:0]     div_next;

    logic                out_valid_reg;
    logic [CW-1:0]       out_px_reg;
    logic [ROW_BITS-1:0] out_py_reg;
    logic [DIV_BITS-1:0] out_div_reg;
    logic                out_last_reg, out_eof_reg;

    assign head = entry_t'(q_data);
    assign en   = !out_valid_reg || out_ready;

    // point sequencer: walks the head entry's mask lowest point first
    assign avail = head.mask & ~issued_reg;

    always_comb
    begin
        priority if (avail[PT_INNER])
        begin
            sel = PT_INNER;
        end
        else if (avail[PT_ROW_END])
        begin
            sel = PT_ROW_END;
        end
        else if (avail[PT_LAST_ROW])
        begin
            sel = PT_LAST_ROW;
        end
        else
        begin
            sel = PT_CORNER;
        end
    end

    assign pick  = NUM_POINTS'(1) << sel;
    assign rest  = avail & ~pick;
    assign issue = q_valid && en;
    assign q_pop = issue && (rest == '0);

    always_comb
    begin
        issued_next = issued_reg;
        if (issue)
        begin
            issued_next = (rest == '0) ? '0 : (issued_reg | pick);
        end
    end

    assign prod_x = $signed(head.dx[sel]) * $signed({1'b0, x_inv});
    assign prod_y = $signed(head.dy[sel]) * $signed({1'b0, y_inv});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg    <= '0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            issued_reg <= issued_next;
            if (en)
            begin
                m_valid_reg   <= issue;
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_x_reg <= prod_x;
            m_prod_y_reg <= prod_y;
            m_x_one_reg  <= head.x_one[sel];
            m_y_one_reg  <= head.y_one[sel];
            m_px_reg     <= (sel == PT_INNER || sel == PT_LAST_ROW) ? head.col - CW'(1)
                                                                    : head.col;
            m_py_reg     <= (sel == PT_INNER || sel == PT_ROW_END) ? head.row - ROW_BITS'(1)
                                                                   : head.row;
            m_last_reg   <= (rest == '0);
            m_eof_reg    <= (sel == PT_CORNER);

            out_px_reg   <= m_px_reg;
            out_py_reg   <= m_py_reg;
            out_div_reg  <= div_next;
            out_last_reg <= m_last_reg;
            out_eof_reg  <= m_eof_reg;
        end
    end

    // one-sided terms count twice, then floor shift and clamp to 24 bits
    always_comb
    begin
        tx_ext  = SUM_W'(m_prod_x_reg);
        ty_ext  = SUM_W'(m_prod_y_reg);
        if (m_x_one_reg)
        begin
            tx_ext = tx_ext <<< 1;
        end
        if (m_y_one_reg)
        begin
            ty_ext = ty_ext <<< 1;
        end
        sum     = tx_ext + ty_ext;
        shifted = sum >>> SHIFT;
        if (shifted > SAT_HI)
        begin
            div_next = SAT_HI[DIV_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            div_next = SAT_LO[DIV_BITS-1:0];
        end
        else
        begin
            div_next = shifted[DIV_BITS-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = out_px_reg;
    assign point_y      = out_py_reg;
    assign divergence   = out_div_reg;
    assign last_of_run  = out_last_reg;
    assign end_of_frame = out_eof_reg;

endmodule

[rtl/core/grid_divergence_stencil.sv]
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: vx_sample, vy_sample
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: point_x, point_y, divergence;
//          |           |                              | tlast: last_of_run; tuser: end_of_frame
// cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// one sample per cycle in and one result per cycle out while nothing stalls; a sample is
// registered at the input, then queued, and its results pass the multiply and output registers.
// past column 0, rows 1 to H-2 give one result per sample plus one at the row end, the last
// row at least two, so input is held back by the single result port behind the 4-entry queue.
// one line ram of MAX_WIDTH words keeps the previous rows; one read and one write per cycle.
// reset clears counters and pipeline valids, presets config; the line ram is not cleared.
// output backpressure stalls the result pipeline first, then the queue, then s_axis_tready.
module grid_divergence_stencil #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int IN_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((CW + gds_pkg::ROW_BITS + gds_pkg::DIV_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [IN_W-1:0]                     s_axis_tdata,  // vx_sample, vy_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_W-1:0]                    m_axis_tdata,  // point_x, point_y, divergence
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser,  // end_of_frame
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gds_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import gds_pkg::*;

    localparam int DW      = SAMPLE_BITS + 1;
    localparam int ENTRY_W = entry_bits(CW, DW);

    logic [GRID_W_BITS-1:0] grid_width_reg;
    logic [ROW_BITS-1:0]    grid_height_reg;
    logic [INV_BITS-1:0]    x_inv_reg, y_inv_reg;
    logic                   cfg_wr;
    dims_t                  dims;

    logic               q_push, q_full, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    logic [CW-1:0]       point_x;
    logic [ROW_BITS-1:0] point_y;
    logic [DIV_BITS-1:0] divergence;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_W_RESET;
            grid_height_reg <= GRID_H_RESET;
            x_inv_reg       <= INV_RESET;
            y_inv_reg       <= INV_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_W_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[ROW_BITS-1:0];
                REG_X_INV:       x_inv_reg       <= cfg_data[INV_BITS-1:0];
                REG_Y_INV:       y_inv_reg       <= cfg_data[INV_BITS-1:0];
            endcase
        end
    end

    // a new grid size restarts the frame
    always_comb
    begin
        dims.grid_width  = grid_width_reg;
        dims.grid_height = grid_height_reg;
        dims.restart     = cfg_wr && (cfg_index == REG_GRID_WIDTH ||
                                      cfg_index == REG_GRID_HEIGHT);
    end

    gds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .dims     (dims),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .vx_sample(s_axis_tdata[SAMPLE_BITS-1:0]),
        .vy_sample(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    gds_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .full (q_full),
        .valid(q_valid),
        .rdata(q_rdata),
        .pop  (q_pop)
    );

    gds_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_inv       (x_inv_reg),
        .y_inv       (y_inv_reg),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .divergence  (divergence),
        .last_of_run (m_axis_tlast),
        .end_of_frame(m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({divergence, point_y, point_x});

endmodule
